/* rtl/core/word_tape_operator_engine_core_defines.svh */
// ----------------------------------------------------------------------------
// word tape operator engine assertion macros
// shared concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef WORD_TAPE_OPERATOR_ENGINE_CORE_DEFINES_SVH
`define WORD_TAPE_OPERATOR_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WTOE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wtoe assertion failed");
// next-cycle implication
`define WTOE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wtoe assertion failed");
`else
`define WTOE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WTOE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/wtoe_pkg.sv */
// ----------------------------------------------------------------------------
// wtoe_pkg
// shared widths, operation codes and transaction types of the tape engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wtoe_pkg;

   localparam int WORD_W     = 64;
   localparam int SLOT_COUNT = 32;
   // slot count is a power of two, so the modulo is a plain bit select
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int IDX_W      = 5;
   localparam int OP_W       = 3;
   localparam int AMT_W      = 6;
   localparam int REQ_DATA_W = 80;

   localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
   localparam logic [OP_W-1:0] OP_READ   = 3'd1;
   localparam logic [OP_W-1:0] OP_XOR    = 3'd2;
   localparam logic [OP_W-1:0] OP_ROTL   = 3'd3;
   localparam logic [OP_W-1:0] OP_ROTR   = 3'd4;
   localparam logic [OP_W-1:0] OP_SWAP   = 3'd5;
   localparam logic [OP_W-1:0] OP_GATHER = 3'd6;

   // one captured request
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] slot_a;
      logic [SLOT_W-1:0] slot_b;
      logic [WORD_W-1:0] value;
      logic [AMT_W-1:0]  amount;
      logic              last;
   } req_item_type;

   // what the operation unit asks the sequencer to commit
   typedef struct packed {
      logic              wr_a;
      logic [WORD_W-1:0] wr_a_data;
      logic [WORD_W-1:0] acc_next;
      logic [WORD_W-1:0] result;
   } op_result_type;

endpackage

/* rtl/core/wtoe_tape_ram.sv */
// ----------------------------------------------------------------------------
// wtoe_tape_ram
// tape storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtoe_tape_ram (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [wtoe_pkg::SLOT_W-1:0]  rd_a_addr,
   input  logic [wtoe_pkg::SLOT_W-1:0]  rd_b_addr,
   output logic [wtoe_pkg::WORD_W-1:0]  rd_a_data,
   output logic [wtoe_pkg::WORD_W-1:0]  rd_b_data,
   input  logic                         wr_en,
   input  logic [wtoe_pkg::SLOT_W-1:0]  wr_addr,
   input  logic [wtoe_pkg::WORD_W-1:0]  wr_data
);

   logic [wtoe_pkg::WORD_W-1:0] mem [wtoe_pkg::SLOT_COUNT];
   logic [wtoe_pkg::WORD_W-1:0] rd_a_ff;
   logic [wtoe_pkg::WORD_W-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_a_addr];
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

/* rtl/core/wtoe_op_unit.sv */
// ----------------------------------------------------------------------------
// wtoe_op_unit
// computes the new target word, accumulator and response for one request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtoe_op_unit (
   input  wtoe_pkg::req_item_type       item,
   input  logic [wtoe_pkg::WORD_W-1:0]  word_a,
   input  logic [wtoe_pkg::WORD_W-1:0]  word_b,
   input  logic [wtoe_pkg::WORD_W-1:0]  acc,
   output wtoe_pkg::op_result_type      res
);

   logic [2*wtoe_pkg::WORD_W-1:0] rotl_wide;
   logic [2*wtoe_pkg::WORD_W-1:0] rotr_wide;
   logic [wtoe_pkg::WORD_W-1:0]   gather_acc;

   // rotate through a doubled word, a zero amount passes the word through
   assign rotl_wide  = {word_a, word_a} << item.amount;
   assign rotr_wide  = {word_a, word_a} >> item.amount;
   assign gather_acc = acc ^ word_b;

   always_comb begin
      res.wr_a      = 1'b0;
      res.wr_a_data = word_a;
      res.acc_next  = acc;
      res.result    = word_a;
      case (item.op)
         wtoe_pkg::OP_LOAD: begin
            res.wr_a      = 1'b1;
            res.wr_a_data = item.value;
            res.result    = item.value;
         end
         wtoe_pkg::OP_READ: begin
            res.result = word_a;
         end
         wtoe_pkg::OP_XOR: begin
            res.wr_a      = 1'b1;
            res.wr_a_data = word_a ^ item.value;
            res.result    = word_a ^ item.value;
         end
         wtoe_pkg::OP_ROTL: begin
            res.wr_a      = 1'b1;
            res.wr_a_data = rotl_wide[2*wtoe_pkg::WORD_W-1:wtoe_pkg::WORD_W];
            res.result    = rotl_wide[2*wtoe_pkg::WORD_W-1:wtoe_pkg::WORD_W];
         end
         wtoe_pkg::OP_ROTR: begin
            res.wr_a      = 1'b1;
            res.wr_a_data = rotr_wide[wtoe_pkg::WORD_W-1:0];
            res.result    = rotr_wide[wtoe_pkg::WORD_W-1:0];
         end
         wtoe_pkg::OP_SWAP: begin
            // slot b gets the old slot a word in the following cycle
            res.wr_a      = 1'b1;
            res.wr_a_data = word_b;
            res.result    = word_b;
         end
         wtoe_pkg::OP_GATHER: begin
            if (item.last) begin
               res.wr_a      = 1'b1;
               res.wr_a_data = word_a ^ gather_acc;
               res.acc_next  = '0;
               res.result    = word_a ^ gather_acc;
            end else begin
               res.acc_next = gather_acc;
               res.result   = gather_acc;
            end
         end
         default: begin
            res.result = word_a;
         end
      endcase
   end

endmodule

/* rtl/core/word_tape_operator_engine_core.sv */
// A request is taken in idle and executed in exec once the response register
// is free. No new request is taken until idle, after a swap-b state for a swap;
// the tape RAM has a single write port, and a swap writes both of its slots.
// Reset clears the sequencer, the response register and the gather
// accumulator; tape slots hold nothing defined until loaded, with no clear pass.
`timescale 1ns / 1ps
`include "word_tape_operator_engine_core_defines.svh"

// ----------------------------------------------------------------------------
// word_tape_operator_engine_core
// 32-slot tape of 64-bit words with load, read, xor, rotate, swap and gather
// ----------------------------------------------------------------------------
module word_tape_operator_engine_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // slot_a[4:0], slot_b[9:5], value[73:10], rotate_amount[79:74]
   input  logic [wtoe_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type[2:0]
   input  logic [wtoe_pkg::OP_W-1:0]            req_tuser,
   input  logic                                 req_tlast,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result_word[63:0]
   output logic [wtoe_pkg::WORD_W-1:0]          rsp_tdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_SWAPB = 2'd2;

   logic [1:0]                  state_ff;
   logic [1:0]                  state_in;
   wtoe_pkg::req_item_type      item_ff;
   wtoe_pkg::req_item_type      req_item;
   logic [wtoe_pkg::WORD_W-1:0] acc_ff;
   logic [wtoe_pkg::WORD_W-1:0] acc_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [wtoe_pkg::WORD_W-1:0] rsp_data_ff;
   logic [wtoe_pkg::WORD_W-1:0] rsp_data_in;

   logic                        req_xfer;
   logic                        out_free;
   logic                        exec_go;
   logic [wtoe_pkg::WORD_W-1:0] word_a;
   logic [wtoe_pkg::WORD_W-1:0] word_b;
   logic                        wr_en;
   logic [wtoe_pkg::SLOT_W-1:0] wr_addr;
   logic [wtoe_pkg::WORD_W-1:0] wr_data;
   wtoe_pkg::op_result_type     op_res;

   // unpack the request transaction, slots reduced to the tape size
   assign req_item.op     = req_tuser;
   assign req_item.slot_a = req_tdata[wtoe_pkg::SLOT_W-1:0];
   assign req_item.slot_b = req_tdata[wtoe_pkg::IDX_W+wtoe_pkg::SLOT_W-1:wtoe_pkg::IDX_W];
   assign req_item.value  = req_tdata[2*wtoe_pkg::IDX_W+wtoe_pkg::WORD_W-1:2*wtoe_pkg::IDX_W];
   assign req_item.amount = req_tdata[wtoe_pkg::REQ_DATA_W-1:
                                      wtoe_pkg::REQ_DATA_W-wtoe_pkg::AMT_W];
   assign req_item.last   = req_tlast;

   // one request in flight; reads start only after the last write lands
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign exec_go    = (state_ff == ST_EXEC) && out_free;

   wtoe_tape_ram u_tape (
      .clock     (clock),
      .rd_en     (req_xfer),
      .rd_a_addr (req_item.slot_a),
      .rd_b_addr (req_item.slot_b),
      .rd_a_data (word_a),
      .rd_b_data (word_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   wtoe_op_unit u_op (
      .item   (item_ff),
      .word_a (word_a),
      .word_b (word_b),
      .acc    (acc_ff),
      .res    (op_res)
   );

   // write back: target slot on execute, second swap slot in the cycle after
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = item_ff.slot_a;
      wr_data = op_res.wr_a_data;
      if (state_ff == ST_SWAPB) begin
         wr_en   = 1'b1;
         wr_addr = item_ff.slot_b;
         wr_data = word_a;
      end else if (exec_go) begin
         wr_en = op_res.wr_a;
      end
   end

   // sequencer and response register
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               acc_in       = op_res.acc_next;
               rsp_valid_in = 1'b1;
               rsp_data_in  = op_res.result;
               state_in     = (item_ff.op == wtoe_pkg::OP_SWAP) ? ST_SWAPB : ST_IDLE;
            end
         end
         ST_SWAPB: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_item;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `WTOE_ASSERT_NXT(a_accept_to_exec, clock, reset, req_xfer, state_ff == ST_EXEC)
   `WTOE_ASSERT_NXT(a_exec_gives_rsp, clock, reset, exec_go, rsp_valid_ff)
   `WTOE_ASSERT_NXT(a_swap_second_write, clock, reset,
      exec_go && (item_ff.op == wtoe_pkg::OP_SWAP), state_ff == ST_SWAPB)
   `WTOE_ASSERT_NXT(a_gather_clears_acc, clock, reset,
      exec_go && (item_ff.op == wtoe_pkg::OP_GATHER) && item_ff.last, acc_ff == '0)
   `WTOE_ASSERT_IMP(a_no_write_idle, clock, reset, state_ff == ST_IDLE, !wr_en)

endmodule
